[hw/rtl/rkit_pkg.sv]
// Shared types and constants for the key interning table.
package rkit_pkg;
  localparam int unsigned Slots    = 256;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CntW     = 9;
  localparam int unsigned KeyWords = 5;
  localparam int unsigned KeyW     = 64 * KeyWords;
  localparam logic [31:0] GenMax   = 32'hffff_ffff;
  localparam logic [31:0] RefMax   = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_SATURATED = 3'd2,
    ST_INVALID   = 3'd3,
    ST_RANGE     = 3'd4,
    ST_STALE     = 3'd5
  } status_e;

  localparam logic ActAcquire = 1'b0;
  localparam logic ActRelease = 1'b1;

  typedef struct packed {
    logic            action;
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] handle_index;
    logic [31:0]     handle_generation;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdxW-1:0] slot_index;
    logic [31:0]     slot_generation;
    logic            new_entry;
    logic            last_released;
  } rsp_t;
endpackage

[hw/rtl/rkit_if.sv]
// Valid/ready channel carrying one payload.
interface rkit_if #(type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rkit_front.sv]
// Request intake: two-entry queue that decouples the port from the engine.
module rkit_front import rkit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic q_valid_o,
  input  logic q_pop_i,
  output req_t q_req_o
);
  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule

[hw/rtl/rkit_engine.sv]
// Table engine: key search over slots, slot allocation, release and result register.
module rkit_engine import rkit_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CntW-1:0] slot_limit_i,
  input  logic          q_valid_i,
  input  req_t          q_req_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rsp_t          out_rsp_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_READ  = 8'b0000_0010,
    S_CMP   = 8'b0000_0100,
    S_ALLOC = 8'b0000_1000,
    S_AGEN  = 8'b0001_0000,
    S_RREAD = 8'b0010_0000,
    S_REL   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // Slot storage: memories with a registered read port. A slot's generation
  // and count are written when it is first appended, so only counters reset.
  logic [KeyW-1:0] key_mem [Slots];
  logic [31:0]     gen_mem [Slots];
  logic [31:0]     ref_mem [Slots];
  logic [IdxW-1:0] free_mem [Slots];
  logic [KeyW-1:0] key_rd_q;
  logic [31:0]     gen_rd_q, ref_rd_q;
  logic [IdxW-1:0] free_rd_q;

  state_e          st_q, st_d;
  req_t            req_q;
  logic [CntW-1:0] scan_q, scan_d, used_q, used_d, free_q, free_d;
  rsp_t            rsp_q, rsp_d;
  logic            ovalid_q, ovalid_d;
  logic [IdxW-1:0] scan_idx, sel_idx, rd_addr, wr_addr;
  logic [CntW-1:0] limit;
  logic            key_hit, can_alloc, rel_ok;
  logic            key_we, gen_we, ref_we, free_we;
  logic [31:0]     gen_wd, ref_wd;

  assign scan_idx = scan_q[IdxW-1:0];
  assign limit    = (slot_limit_i > CntW'(Slots)) ? CntW'(Slots) : slot_limit_i;
  assign out_valid_o = ovalid_q;
  assign out_rsp_o   = rsp_q;
  assign q_pop_o     = (st_q == S_IDLE) && q_valid_i && !ovalid_q;

  assign sel_idx   = (free_q != '0) ? free_rd_q : used_q[IdxW-1:0];
  assign can_alloc = (free_q != '0) || (used_q < limit);
  assign key_hit   = (ref_rd_q != '0) && (key_rd_q == req_q.key);
  assign rel_ok    = (req_q.handle_generation != '0) &&
                     ({1'b0, req_q.handle_index} < used_q) &&
                     (gen_rd_q == req_q.handle_generation) && (ref_rd_q != '0);
  assign rd_addr   = (st_q == S_RREAD) ? req_q.handle_index :
                     (st_q == S_ALLOC) ? sel_idx : scan_idx;
  assign wr_addr   = (st_q == S_REL) ? req_q.handle_index :
                     (st_q == S_ALLOC) ? sel_idx : scan_idx;

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[wr_addr] <= req_q.key;
    if (gen_we) gen_mem[wr_addr] <= gen_wd;
    if (ref_we) ref_mem[wr_addr] <= ref_wd;
    if (free_we) free_mem[free_q[IdxW-1:0]] <= req_q.handle_index;
    key_rd_q  <= key_mem[rd_addr];
    gen_rd_q  <= gen_mem[rd_addr];
    ref_rd_q  <= ref_mem[rd_addr];
    free_rd_q <= free_mem[IdxW'(free_q - CntW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) req_q <= q_req_i;
  end

  always_comb begin
    st_d = st_q; scan_d = scan_q; used_d = used_q; free_d = free_q;
    rsp_d = rsp_q; ovalid_d = ovalid_q;
    key_we = 1'b0; gen_we = 1'b0; ref_we = 1'b0; free_we = 1'b0;
    gen_wd = 32'd1; ref_wd = 32'd1;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (st_q)
      S_IDLE: begin
        scan_d = '0;
        if (q_pop_o) st_d = (q_req_i.action == ActRelease) ? S_RREAD : S_READ;
      end
      // wait for the registered slot memory read
      S_READ: st_d = (scan_q < used_q) ? S_CMP : S_ALLOC;
      S_CMP: begin
        if (key_hit) begin
          rsp_d = '0;
          if (ref_rd_q == RefMax) rsp_d.status = ST_SATURATED;
          else begin
            ref_we = 1'b1;
            ref_wd = ref_rd_q + 32'd1;
            rsp_d.slot_index = scan_idx;
            rsp_d.slot_generation = gen_rd_q;
          end
          st_d = S_DONE;
        end else begin
          scan_d = scan_q + CntW'(1);
          st_d = S_READ;
        end
      end
      S_ALLOC: begin
        rsp_d = '0;
        st_d = S_DONE;
        if (!can_alloc) rsp_d.status = ST_FULL;
        else begin
          key_we = 1'b1;
          ref_we = 1'b1;
          rsp_d.slot_index = sel_idx;
          rsp_d.new_entry = 1'b1;
          if (free_q != '0) begin
            free_d = free_q - CntW'(1);
            // fetch the generation of the reused slot
            st_d = S_AGEN;
          end else begin
            // first use of a slot: start it at generation 1
            gen_we = 1'b1;
            used_d = used_q + CntW'(1);
            rsp_d.slot_generation = 32'd1;
          end
        end
      end
      S_AGEN: begin
        rsp_d.slot_generation = gen_rd_q;
        st_d = S_DONE;
      end
      S_RREAD: st_d = S_REL;
      S_REL: begin
        rsp_d = '0;
        if (req_q.handle_generation == '0) rsp_d.status = ST_INVALID;
        else if ({1'b0, req_q.handle_index} >= used_q) rsp_d.status = ST_RANGE;
        else if (!rel_ok) rsp_d.status = ST_STALE;
        else begin
          ref_we = 1'b1;
          ref_wd = ref_rd_q - 32'd1;
          if (ref_rd_q == 32'd1) begin
            rsp_d.last_released = 1'b1;
            // an exhausted generation keeps the slot out of the free stack
            if (gen_rd_q != GenMax) begin
              gen_we = 1'b1;
              gen_wd = gen_rd_q + 32'd1;
              if (free_q < CntW'(Slots)) begin
                free_we = 1'b1;
                free_d = free_q + CntW'(1);
              end
            end
          end
        end
        st_d = S_DONE;
      end
      S_DONE: begin
        ovalid_d = 1'b1;
        st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; scan_q <= '0; used_q <= '0; free_q <= '0; ovalid_q <= 1'b0;
      rsp_q <= '0;
    end else begin
      st_q <= st_d; scan_q <= scan_d; used_q <= used_d; free_q <= free_d;
      ovalid_q <= ovalid_d;
      rsp_q <= rsp_d;
    end
  end
endmodule

[hw/rtl/refcounted_key_interning_table.sv]
// Top level of the reference-counted key interning table.
// Usage: requests enter on req (action, five key words, handle index and
// generation); exactly one result leaves on rsp per request (status, slot
// index, slot generation, new-entry and last-released flags). Both are
// valid/ready channels; a request is taken when valid and ready are high.
// The slot_limit register sits at APB address 0 and is to be written by the
// user only while the block is idle; the block itself does not enforce this.
// Reads return it. An acquire reads and compares the used slots one by one
// and stops at a hit; a miss then appends a slot, reuses a freed slot
// (reading its generation) or reports full. A release reads the handle's
// slot, then checks and updates it. The engine takes the next request only
// after the previous result has left. A two-entry request queue keeps
// taking requests while the engine works; results are held in an output
// register until taken, and the engine waits while that register is full.
// Reset clears the slot counters; a slot gets generation 1 and its count
// when first appended, so the table is empty.
module refcounted_key_interning_table import rkit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rkit_if.sink        req,
  rkit_if.source      rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [CntW-1:0] limit_q;
  logic q_valid, q_pop;
  req_t q_req;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {{(32-CntW){1'b0}}, limit_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= CntW'(256);
    else if (psel && penable && pwrite && paddr == 1'b0) limit_q <= pwdata[CntW-1:0];
  end

  rkit_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_req_i(req.data),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  rkit_engine u_engine (
    .clk_i, .rst_ni, .slot_limit_i(limit_q),
    .q_valid_i(q_valid), .q_req_i(q_req), .q_pop_o(q_pop),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .out_rsp_o(rsp.data)
  );
endmodule

[verif/testbench.sv]
// Self-checking testbench for the reference-counted key interning table.
module testbench;
  import rkit_pkg::*;

  localparam int unsigned CycleLimit = 5_000_000;
  localparam int unsigned IdleWait   = 600;   // covers an acquire over all slots
  localparam int unsigned LongHold   = 400;

  typedef enum logic [1:0] {ROW_ACQ, ROW_REL, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [KeyW-1:0] key;
    logic [7:0]  idx;
    logic [31:0] gen;
    logic [8:0]  cfg;
    bit          typed;
    rsp_t        exp;
  } row_t;

  typedef struct {
    logic [7:0]  idx;
    logic [31:0] gen;
  } handle_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rkit_if #(.payload_t(req_t)) req_ch ();
  rkit_if #(.payload_t(rsp_t)) rsp_ch ();

  refcounted_key_interning_table i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Table shadow.
  logic [KeyW-1:0] tbl_key [Slots];
  logic [31:0]     tbl_gen [Slots];
  logic [31:0]     tbl_refs [Slots];
  logic [7:0]      tbl_free [Slots];
  logic [8:0]      tbl_free_cnt, tbl_used_cnt, tbl_limit;

  rsp_t    pending_rsp [$];
  handle_t held [$];
  int      errors = 0;
  int      results_seen = 0;
  int      status_seen [6];
  int      cycles = 0;
  bit      quiet_phase = 1'b0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic rsp_t intern_predict(input req_t r);
    rsp_t o;
    logic [8:0] lim;
    logic [7:0] slot;
    o = '0;
    o.status = ST_OK;
    if (r.action == ActAcquire) begin
      lim = (tbl_limit > 9'(Slots)) ? 9'(Slots) : tbl_limit;
      for (int i = 0; i < tbl_used_cnt; i++) begin
        if (tbl_refs[i] != 0 && tbl_key[i] == r.key) begin
          if (tbl_refs[i] == RefMax) begin
            o.status = ST_SATURATED;
          end else begin
            tbl_refs[i] = tbl_refs[i] + 32'd1;
            o.slot_index = i[7:0];
            o.slot_generation = tbl_gen[i];
          end
          return o;
        end
      end
      if (tbl_free_cnt != 0) begin
        tbl_free_cnt = tbl_free_cnt - 9'd1;
        slot = tbl_free[tbl_free_cnt[7:0]];
      end else if (tbl_used_cnt < lim) begin
        slot = tbl_used_cnt[7:0];
        tbl_used_cnt = tbl_used_cnt + 9'd1;
      end else begin
        o.status = ST_FULL;
        return o;
      end
      tbl_key[slot] = r.key;
      tbl_refs[slot] = 32'd1;
      o.slot_index = slot;
      o.slot_generation = tbl_gen[slot];
      o.new_entry = 1'b1;
    end else begin
      slot = r.handle_index;
      if (r.handle_generation == 0) o.status = ST_INVALID;
      else if ({1'b0, slot} >= tbl_used_cnt) o.status = ST_RANGE;
      else if (tbl_gen[slot] != r.handle_generation || tbl_refs[slot] == 0) o.status = ST_STALE;
      else begin
        tbl_refs[slot] = tbl_refs[slot] - 32'd1;
        if (tbl_refs[slot] == 0) begin
          o.last_released = 1'b1;
          if (tbl_gen[slot] != GenMax) begin
            tbl_gen[slot] = tbl_gen[slot] + 32'd1;
            if (tbl_free_cnt < Slots) begin
              tbl_free[tbl_free_cnt[7:0]] = slot;
              tbl_free_cnt = tbl_free_cnt + 9'd1;
            end
          end
        end
      end
    end
    return o;
  endfunction

  // Offer one request after a gap; predict at acceptance.
  task automatic send_req(input req_t r, input int gap, input bit typed, input rsp_t exp);
    rsp_t p;
    handle_t h;
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    p = intern_predict(r);
    pending_rsp.push_back(typed ? exp : p);
    if (r.action == ActAcquire && p.status == ST_OK) begin
      h.idx = p.slot_index;
      h.gen = p.slot_generation;
      held.push_back(h);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [8:0] v);
    drain();
    repeat (IdleWait) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 1'b0; pwdata <= {23'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tbl_limit = v;
    // read back
    @(negedge clk_i);
    psel <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[8:0] !== v) begin
      $display("%0t slot_limit readback: expected %0d actual %0d", $time, v, prdata[8:0]);
      errors++;
    end
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  function automatic row_t mk(input row_kind_e k, input logic [KeyW-1:0] key,
                              input logic [7:0] idx, input logic [31:0] gen,
                              input bit typed, input logic [2:0] st, input logic [7:0] si,
                              input logic [31:0] sg, input logic ne, input logic lr);
    row_t w;
    w.kind = k; w.key = key; w.idx = idx; w.gen = gen; w.cfg = key[8:0];
    w.typed = typed;
    w.exp.status = st; w.exp.slot_index = si; w.exp.slot_generation = sg;
    w.exp.new_entry = ne; w.exp.last_released = lr;
    return w;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin : stimulus
    row_t rows [$];
    logic [KeyW-1:0] kzero, kones, kmix, knew;
    logic [KeyW-1:0] pool [$];
    logic [8:0] limits [7];
    req_t r;
    rsp_t none;
    handle_t h;
    int pick, gap, pool_size;

    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    none = '0;
    for (int i = 0; i < Slots; i++) begin
      tbl_gen[i] = 32'd1;
      tbl_refs[i] = 32'd0;
    end
    tbl_free_cnt = 9'd0; tbl_used_cnt = 9'd0; tbl_limit = 9'd256;

    kzero = '0;
    kones = '1;
    kmix  = {5{64'haaaa_5555_f0f0_0f0f}};
    knew  = {5{64'h0123_4567_89ab_cdef}};
    rows.push_back(mk(ROW_ACQ, kzero, 0, 0, 1, ST_OK, 0, 1, 1, 0));
    rows.push_back(mk(ROW_ACQ, kzero, 0, 0, 1, ST_OK, 0, 1, 0, 0));
    rows.push_back(mk(ROW_ACQ, kones, 0, 0, 1, ST_OK, 1, 1, 1, 0));
    rows.push_back(mk(ROW_ACQ, kmix, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd0, 32'd0, 1, ST_INVALID, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd255, 32'd1, 1, ST_RANGE, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd0, 32'hffff_ffff, 1, ST_STALE, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd0, 32'd1, 1, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd0, 32'd1, 1, ST_OK, 0, 0, 0, 1));
    rows.push_back(mk(ROW_REL, '0, 8'd0, 32'd1, 1, ST_STALE, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd1, 32'd1, 1, ST_OK, 0, 0, 0, 1));
    rows.push_back(mk(ROW_ACQ, kmix, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_ACQ, kzero, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_ACQ, kones, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_CFG, 320'd3, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_ACQ, knew, 0, 0, 1, ST_FULL, 0, 0, 0, 0));
    rows.push_back(mk(ROW_CFG, 320'd0, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_ACQ, knew, 0, 0, 1, ST_FULL, 0, 0, 0, 0));
    rows.push_back(mk(ROW_CFG, 320'd511, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_ACQ, knew, 0, 0, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd3, 32'd1, 0, ST_OK, 0, 0, 0, 0));
    rows.push_back(mk(ROW_REL, '0, 8'd2, 32'd1, 0, ST_OK, 0, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[n]) begin
      if (rows[n].kind == ROW_CFG) begin
        write_limit(rows[n].cfg);
      end else begin
        r = '0;
        r.action = (rows[n].kind == ROW_REL) ? ActRelease : ActAcquire;
        r.key = rows[n].key;
        r.handle_index = rows[n].idx;
        r.handle_generation = rows[n].gen;
        send_req(r, $urandom_range(0, 3), rows[n].typed, rows[n].exp);
      end
    end

    limits = '{9'd256, 9'd8, 9'd1, 9'd0, 9'd511, 9'd16, 9'd40};
    limits[5] = 9'($urandom_range(1, 40));
    for (int ph = 0; ph < 7; ph++) begin
      write_limit(limits[ph]);
      quiet_phase = (ph % 3 == 2);
      pool_size = (ph == 4) ? 64 : $urandom_range(4, 24);
      pool.delete();
      for (int k = 0; k < pool_size; k++)
        pool.push_back({rand64(), rand64(), rand64(), rand64(), rand64()});
      for (int n = 0; n < 250; n++) begin
        // let the table settle once mid-phase
        if (n == 125) drain();
        gap = quiet_phase ? 0 : $urandom_range(0, 17);
        r = '0;
        r.key = {rand64(), rand64(), rand64(), rand64(), rand64()};
        r.handle_index = 8'($urandom());
        r.handle_generation = $urandom();
        if ($urandom_range(0, 99) < 55) begin
          r.action = ActAcquire;
          if ($urandom_range(0, 9) != 0) r.key = pool[$urandom_range(0, pool.size() - 1)];
        end else begin
          r.action = ActRelease;
          if (held.size() != 0 && $urandom_range(0, 99) < 85) begin
            pick = $urandom_range(0, held.size() - 1);
            h = held[pick];
            held.delete(pick);
            r.handle_index = h.idx;
            r.handle_generation = h.gen;
          end else begin
            case ($urandom_range(0, 2))
              0: r.handle_generation = 32'd0;
              1: r.handle_generation = $urandom_range(1, 4);
              default: ;
            endcase
            if ($urandom_range(0, 1) == 0) r.handle_index = 8'($urandom_range(0, 31));
          end
        end
        send_req(r, gap, 1'b0, none);
      end
    end

    drain();
    repeat (IdleWait) @(posedge clk_i);
    $display("covered %0d results over 7 limit settings: ok %0d full %0d invalid %0d",
             results_seen, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_INVALID]);
    $display("range errors %0d, stale handles %0d, slots in use %0d",
             status_seen[ST_RANGE], status_seen[ST_STALE], tbl_used_cnt);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : collector
    int stall;
    rsp_t want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      // hold off long once so the request queue fills up
      stall = (results_seen == 300) ? LongHold : (quiet_phase ? 0 : $urandom_range(0, 17));
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      results_seen++;
      if (rsp_ch.data.status < 6) status_seen[rsp_ch.data.status]++;
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, rsp_ch.data);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.data.status !== want.status ||
            rsp_ch.data.slot_index !== want.slot_index ||
            rsp_ch.data.slot_generation !== want.slot_generation ||
            rsp_ch.data.new_entry !== want.new_entry ||
            rsp_ch.data.last_released !== want.last_released) begin
          $display("%0t mismatch: expected st=%0d idx=%0d gen=%0d new=%0b last=%0b",
                   $time, want.status, want.slot_index, want.slot_generation,
                   want.new_entry, want.last_released);
          $display("%0t           actual st=%0d idx=%0d gen=%0d new=%0b last=%0b",
                   $time, rsp_ch.data.status, rsp_ch.data.slot_index,
                   rsp_ch.data.slot_generation, rsp_ch.data.new_entry,
                   rsp_ch.data.last_released);
          errors++;
        end
      end
    end
  end
endmodule

[sim.f]
hw/rtl/rkit_pkg.sv
hw/rtl/rkit_if.sv
hw/rtl/rkit_front.sv
hw/rtl/rkit_engine.sv
hw/rtl/refcounted_key_interning_table.sv
verif/testbench.sv
